// ===== rtl/core/okl_pkg.sv =====
// okl_pkg: shared types and codes for the ordered key list.
// Holds request/response structs, function and status codes, cell modes
// and the control state type. No dependencies.
package okl_pkg;

  localparam int KEY_W   = 32;
  localparam int FUNC_W  = 3;
  localparam int INDEX_W = 4;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;

  // Request function codes
  localparam logic [FUNC_W-1:0] FUNC_PUSH   = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_DELETE = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_READ   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd4;

  // Response status codes
  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd2;
  localparam logic [STAT_W-1:0] STAT_BAD_INDEX = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0]       func;
    logic signed [KEY_W-1:0] key;
    logic [INDEX_W-1:0]      index;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic [COUNT_W-1:0]      count;
    logic signed [KEY_W-1:0] read_key;
  } rsp_t;

  // What a cell loads on the update cycle
  typedef enum logic [2:0] {
    CM_HOLD,
    CM_NEW,
    CM_LEFT,
    CM_RIGHT,
    CM_CLEAR
  } cell_mode_t;

  // Broadcast to every cell
  typedef struct packed {
    logic                    eval;
    logic [FUNC_W-1:0]       func;
    logic signed [KEY_W-1:0] key;
  } cell_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } okl_state_t;

endpackage

// ===== rtl/core/okl_cell.sv =====
// okl_cell: one position of the ordered key list.
// Holds a key and an occupied bit, evaluates its own position flag
// against its left neighbor. Depends on okl_pkg.
module okl_cell (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            head,
  input  okl_pkg::cell_cmd_t              cmd,
  input  okl_pkg::cell_mode_t             mode,
  input  logic signed [okl_pkg::KEY_W-1:0] left_key,
  input  logic                            left_occ,
  input  logic signed [okl_pkg::KEY_W-1:0] right_key,
  input  logic                            right_occ,
  output logic signed [okl_pkg::KEY_W-1:0] key,
  output logic                            occ,
  output logic                            flag
);

  logic flag_next;

  // Flag marks where this request lands: insert point or a match.
  always_comb begin
    unique case (cmd.func)
      okl_pkg::FUNC_PUSH:   flag_next = head;
      okl_pkg::FUNC_INSERT: begin
        if (head) begin
          flag_next = !occ || (cmd.key < key);
        end else begin
          // tail slot, or left < key <= self
          flag_next = left_occ && (!occ || ((left_key < cmd.key) && !(key < cmd.key)));
        end
      end
      okl_pkg::FUNC_DELETE: flag_next = occ && (key == cmd.key);
      default:              flag_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flag <= 1'b0;
      occ  <= 1'b0;
    end else begin
      if (cmd.eval) begin
        flag <= flag_next;
      end
      unique case (mode)
        okl_pkg::CM_NEW:   occ <= 1'b1;
        okl_pkg::CM_LEFT:  occ <= left_occ;
        okl_pkg::CM_RIGHT: occ <= right_occ;
        okl_pkg::CM_CLEAR: occ <= 1'b0;
        default:           occ <= occ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (mode)
      okl_pkg::CM_NEW:   key <= cmd.key;
      okl_pkg::CM_LEFT:  key <= left_key;
      okl_pkg::CM_RIGHT: key <= right_key;
      default:           key <= key;
    endcase
  end

endmodule

// ===== rtl/core/okl_select.sv =====
// okl_select: picks the lowest set flag of the cell row.
// Gives the one-hot pick and the mask of positions behind it.
// Depends on nothing but its parameter.
module okl_select #(
  parameter int N = 16
) (
  input  logic [N-1:0] flags,
  output logic [N-1:0] first,
  output logic [N-1:0] after,
  output logic         any
);

  logic [N-1:0] upto;

  // flags ^ (flags - 1) sets every bit up to and including the lowest one
  assign upto  = flags ^ (flags - N'(1));
  assign any   = |flags;
  assign first = flags & upto;
  assign after = any ? ~upto : '0;

endmodule

// ===== rtl/core/ordered_key_list.sv =====
// ordered_key_list: top level of the bounded signed key list.
// Builds the row of okl_cell instances, the okl_select picker and the
// request sequencer. Depends on okl_pkg, okl_cell, okl_select.
//
//  channel | signals                   | carries
//  --------+---------------------------+--------------------------------------
//  request | req_valid, req_ready, req | func, key, index (okl_pkg::req_t)
//  result  | rsp_valid, rsp_ready, rsp | status, count, read_key (rsp_t)
//
// A request passes through accept, compare and update. In the compare
// cycle every cell checks the key against itself and its left neighbor
// and registers a flag; in the update cycle the lowest flag is picked and
// each cell loads from its left, its right, the new key, clears, or holds.
// The update cycle waits while a finished result is not yet taken; the
// next request is taken once the update has committed.
// Reset (rst, synchronous) empties the list at once; keys are not cleared.
module ordered_key_list #(
  parameter int CAPACITY = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  okl_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output okl_pkg::rsp_t  rsp
);

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  // Index field reaches only the first 2**INDEX_W positions
  localparam int READ_N = (CAPACITY < (1 << okl_pkg::INDEX_W)) ?
                          CAPACITY : (1 << okl_pkg::INDEX_W);

  okl_pkg::okl_state_t state, state_next;
  okl_pkg::req_t       op;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  logic signed [okl_pkg::KEY_W-1:0] rd_key;
  logic signed [okl_pkg::KEY_W-1:0] rd_pick;
  logic                rd_ok;

  logic                eval;
  logic                commit;

  okl_pkg::cell_cmd_t  cmd;
  okl_pkg::cell_mode_t mode [CAPACITY];
  logic signed [okl_pkg::KEY_W-1:0] cell_key [CAPACITY];
  logic [CAPACITY-1:0] occ_vec;
  logic [CAPACITY-1:0] flag_vec;
  logic [CAPACITY-1:0] first;
  logic [CAPACITY-1:0] after;
  logic                any;
  logic                full;

  okl_pkg::rsp_t       rsp_next;

  // ---------------------------------------------------------------- control
  always_comb begin
    state_next = state;
    unique case (state)
      okl_pkg::ST_IDLE: if (req_valid) state_next = okl_pkg::ST_CMP;
      okl_pkg::ST_CMP:  state_next = okl_pkg::ST_UPD;
      okl_pkg::ST_UPD:  if (!rsp_valid || rsp_ready) state_next = okl_pkg::ST_IDLE;
      default:          state_next = okl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    eval      = 1'b0;
    commit    = 1'b0;
    unique case (state)
      okl_pkg::ST_IDLE: req_ready = 1'b1;
      okl_pkg::ST_CMP:  eval = 1'b1;
      okl_pkg::ST_UPD:  commit = !rsp_valid || rsp_ready;
      default:          req_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= okl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the request for the compare and update cycles
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      op <= req;
    end
  end

  // ------------------------------------------------------------- cell row
  assign cmd.eval = eval;
  assign cmd.func = op.func;
  assign cmd.key  = op.key;

  for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
    logic signed [okl_pkg::KEY_W-1:0] lkey, rkey;
    logic                             locc, rocc;
    if (j == 0) begin : g_head
      assign lkey = '0;
      assign locc = 1'b0;
    end else begin : g_body
      assign lkey = cell_key[j-1];
      assign locc = occ_vec[j-1];
    end
    if (j == CAPACITY - 1) begin : g_tail
      assign rkey = '0;
      assign rocc = 1'b0;
    end else begin : g_inner
      assign rkey = cell_key[j+1];
      assign rocc = occ_vec[j+1];
    end

    okl_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .head      (j == 0),
      .cmd       (cmd),
      .mode      (mode[j]),
      .left_key  (lkey),
      .left_occ  (locc),
      .right_key (rkey),
      .right_occ (rocc),
      .key       (cell_key[j]),
      .occ       (occ_vec[j]),
      .flag      (flag_vec[j])
    );
  end

  okl_select #(.N(CAPACITY)) u_select (
    .flags (flag_vec),
    .first (first),
    .after (after),
    .any   (any)
  );

  assign full = (count == CNT_W'(CAPACITY));

  // Per-cell load selection on the committing update cycle
  always_comb begin
    for (int j = 0; j < CAPACITY; j++) begin
      mode[j] = okl_pkg::CM_HOLD;
      if (commit) begin
        unique case (op.func)
          okl_pkg::FUNC_PUSH, okl_pkg::FUNC_INSERT: begin
            if (!full) begin
              if (first[j])      mode[j] = okl_pkg::CM_NEW;
              else if (after[j]) mode[j] = okl_pkg::CM_LEFT;
            end
          end
          okl_pkg::FUNC_DELETE: begin
            // close the gap from the match onward
            if (first[j] || after[j]) mode[j] = okl_pkg::CM_RIGHT;
          end
          okl_pkg::FUNC_CLEAR: mode[j] = okl_pkg::CM_CLEAR;
          default:             mode[j] = okl_pkg::CM_HOLD;
        endcase
      end
    end
  end

  // ------------------------------------------------------------ read path
  // Select the addressed cell; positions past READ_N are out of reach
  always_comb begin
    rd_pick = '0;
    for (int j = 0; j < READ_N; j++) begin
      if (op.index == okl_pkg::INDEX_W'(j)) rd_pick = cell_key[j];
    end
  end

  always_ff @(posedge clk) begin
    if (eval) begin
      rd_ok  <= (CNT_W + okl_pkg::INDEX_W)'(op.index) < (CNT_W + okl_pkg::INDEX_W)'(count);
      rd_key <= rd_pick;
    end
  end

  // --------------------------------------------------------- result build
  always_comb begin
    count_next        = count;
    rsp_next.status   = okl_pkg::STAT_OK;
    rsp_next.read_key = '0;
    unique case (op.func)
      okl_pkg::FUNC_PUSH, okl_pkg::FUNC_INSERT: begin
        if (full) rsp_next.status = okl_pkg::STAT_FULL;
        else      count_next = count + CNT_W'(1);
      end
      okl_pkg::FUNC_DELETE: begin
        if (any) count_next = count - CNT_W'(1);
        else     rsp_next.status = okl_pkg::STAT_NOT_FOUND;
      end
      okl_pkg::FUNC_READ: begin
        if (rd_ok) rsp_next.read_key = rd_key;
        else       rsp_next.status = okl_pkg::STAT_BAD_INDEX;
      end
      okl_pkg::FUNC_CLEAR: count_next = '0;
      default:             count_next = count;
    endcase
    // count reported modulo 2**COUNT_W
    rsp_next.count = okl_pkg::COUNT_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (commit) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      rsp <= rsp_next;
    end
  end

  // ----------------------------------------------------------- assertions
  a_count_matches_occ: assert property (@(posedge clk) disable iff (rst)
    int'(count) == $countones(occ_vec))
    else $error("count disagrees with occupied cells");

  a_occ_prefix: assert property (@(posedge clk) disable iff (rst)
    ((occ_vec + CAPACITY'(1)) & occ_vec) == '0)
    else $error("occupied cells are not a prefix of the row");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(count) <= CAPACITY)
    else $error("count above capacity");

  a_pick_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(first))
    else $error("more than one cell picked");

  a_commit_releases: assert property (@(posedge clk) disable iff (rst)
    commit |=> (req_ready && rsp_valid))
    else $error("committed update did not present a result and free the input");

endmodule
